/* hw/rtl/sdc_pkg.sv */
// Shared types and constants of the decimal computer.
package sdc_pkg;
	localparam int NUM_REGS  = 10;
	localparam int MEM_WORDS = 100;
	localparam int WORD_W    = 15;
	localparam int ADDR_W    = 7;
	localparam int REG_W     = 4;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;
	localparam logic signed [WORD_W-1:0] WORD_MIN = -15'sd9999;

	localparam logic [3:0] OP_HALT   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_STORE  = 4'd2;
	localparam logic [3:0] OP_ADD    = 4'd3;
	localparam logic [3:0] OP_NEG    = 4'd4;
	localparam logic [3:0] OP_LDI    = 4'd5;
	localparam logic [3:0] OP_ADDI   = 4'd6;
	localparam logic [3:0] OP_JMP    = 4'd7;
	localparam logic [3:0] OP_BSIGN  = 4'd8;

	localparam logic [3:0] IO_READ   = 4'd0;
	localparam logic [3:0] IO_PRINT  = 4'd1;
	localparam logic [3:0] IO_STRING = 4'd2;
	localparam logic [3:0] IO_UNKNOWN_LO = 4'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HALTED    = 3'd1;
	localparam logic [2:0] ST_NOT_RUN   = 3'd2;
	localparam logic [2:0] ST_PC_RANGE  = 3'd3;
	localparam logic [2:0] ST_UNK_IO    = 3'd4;
	localparam logic [2:0] ST_SATURATED = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;

	typedef struct packed {
		logic [3:0]        op;
		logic [REG_W-1:0]  r;
		logic [ADDR_W-1:0] mm;
		logic              neg;
	} dec_t;
endpackage

/* hw/rtl/decimal_computer_instruction_step.sv */
// Top level of the decimal computer: control sequencer, register file and memory.
//
// Input channel (in_valid/in_ready) takes one word: operation 0 stores
// load_value (clamped to +/-9999) at address, operation 1 runs the next
// instruction. Output channel (out_valid/out_ready) gives one word per item,
// or one word per printed character for the string instruction, the final
// word marked by last.
// An instruction passes through the fetch read, decode and execute, and a
// second memory read for memory operands. The string instruction first
// scans memory one word per cycle to find its length, then reads and sends
// one character at a time, each read only after the last one is sent. One
// item is in work at a time; in_ready is high while the sequencer is idle,
// even when a result still waits in the output register.
// Reset clears pc, registers and the memory valid bits (all words read as
// zero) and sets the machine running. A stalled receiver holds the result
// in the output register and the sequencer waits before the next result.
module decimal_computer_instruction_step #(
	parameter int MAX_STRING = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic [sdc_pkg::ADDR_W-1:0]         address,
	input  logic signed [sdc_pkg::WORD_W-1:0]  load_value,
	input  logic [7:0]                         char_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic                               char_valid,
	output logic [7:0]                         char_out,
	output logic [sdc_pkg::ADDR_W-1:0]         program_counter,
	output logic signed [sdc_pkg::WORD_W-1:0]  instruction,
	output logic                               is_running,
	output logic                               last
);
	import sdc_pkg::*;

	localparam int NW = $clog2(MAX_STRING + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FETCH = 9'b000000010,
		S_DEC   = 9'b000000100,
		S_EXEC  = 9'b000001000,
		S_MEM   = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_SRD   = 9'b001000000,
		S_SOUT  = 9'b010000000,
		S_RES   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]        pc_q;
	logic                     run_q;
	logic signed [WORD_W-1:0] ir_q;
	logic signed [WORD_W-1:0] regs_q [NUM_REGS];
	logic [MEM_WORDS-1:0]     vld_q;
	logic                     rvld_q;
	logic [7:0]               char_q;
	dec_t                     dec_q;
	dec_t                     dec_w;
	logic [7:0]               addr_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            k_q;
	logic [2:0]               str_st_q;
	logic [2:0]               res_status_q;
	logic                     res_cv_q;
	logic [7:0]               res_char_q;
	logic signed [WORD_W-1:0] res_instr_q;

	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [WORD_W-1:0]        mem_wdata;
	logic                     mem_re;
	logic [ADDR_W-1:0]        mem_raddr;
	logic [WORD_W-1:0]        mem_rdata;

	logic signed [WORD_W-1:0] rword;
	logic signed [WORD_W-1:0] rval;
	logic signed [WORD_W-1:0] imm;
	logic signed [WORD_W:0]   sum;
	logic signed [WORD_W-1:0] sum_sat;
	logic                     sum_ovf;
	logic signed [WORD_W-1:0] load_clamped;
	logic                     in_acc;
	logic                     slot_free;
	logic                     res_fire;
	logic [7:0]               scan_next;
	logic [7:0]               str_addr;

	sdc_decode u_dec (
		.word (ir_q),
		.dec  (dec_w)
	);

	sdc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;
	assign res_fire  = ((state_q == S_RES) || (state_q == S_SOUT)) && slot_free;

	// Words never written read as zero.
	assign rword = rvld_q ? $signed(mem_rdata) : '0;
	assign rval  = regs_q[dec_q.r];
	assign imm   = dec_q.neg ? -$signed({8'd0, dec_q.mm}) : $signed({8'd0, dec_q.mm});
	assign scan_next = addr_q + 8'd1;
	assign str_addr  = {1'b0, dec_q.mm} + 8'(k_q);

	always_comb begin
		if (load_value > WORD_MAX) begin
			load_clamped = WORD_MAX;
		end else if (load_value < WORD_MIN) begin
			load_clamped = WORD_MIN;
		end else begin
			load_clamped = load_value;
		end
	end

	always_comb begin
		sum = {rval[WORD_W-1], rval} +
			((state_q == S_MEM) ? {rword[WORD_W-1], rword} : {imm[WORD_W-1], imm});
		sum_ovf = (sum > 16'sd9999) || (sum < -16'sd9999);
		if (sum > 16'sd9999) begin
			sum_sat = WORD_MAX;
		end else if (sum < -16'sd9999) begin
			sum_sat = WORD_MIN;
		end else begin
			sum_sat = sum[WORD_W-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = address;
		mem_wdata = load_clamped;
		mem_re    = 1'b0;
		mem_raddr = pc_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !operation && (address < ADDR_W'(MEM_WORDS))) begin
					mem_we = 1'b1;
				end
				if (in_acc && operation && run_q && (pc_q < ADDR_W'(MEM_WORDS))) begin
					mem_re = 1'b1;
				end
			end
			S_EXEC: begin
				mem_raddr = dec_q.mm;
				mem_waddr = dec_q.mm;
				mem_wdata = rval;
				if (dec_q.op == OP_LOAD || dec_q.op == OP_ADD ||
					(dec_q.op > OP_BSIGN && dec_q.r == IO_STRING)) begin
					mem_re = 1'b1;
				end
				if (dec_q.op == OP_STORE) begin
					mem_we = 1'b1;
				end
			end
			S_SCAN: begin
				mem_raddr = scan_next[ADDR_W-1:0];
				if (addr_q < 8'(MEM_WORDS) && n_q != NW'(MAX_STRING) && rword != 0 &&
					scan_next < 8'(MEM_WORDS)) begin
					mem_re = 1'b1;
				end
			end
			S_SRD: begin
				mem_raddr = str_addr[ADDR_W-1:0];
				mem_re    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (mem_re) begin
				rvld_q <= vld_q[mem_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_q <= char_in;
		end
		if (state_q == S_DEC) begin
			dec_q <= dec_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pc_q         <= '0;
			run_q        <= 1'b1;
			ir_q         <= '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			addr_q       <= '0;
			n_q          <= '0;
			k_q          <= '0;
			str_st_q     <= ST_OK;
			res_status_q <= ST_OK;
			res_cv_q     <= 1'b0;
			res_char_q   <= '0;
			res_instr_q  <= '0;
			out_valid    <= 1'b0;
			status       <= ST_OK;
			char_valid   <= 1'b0;
			char_out     <= '0;
			program_counter <= '0;
			instruction  <= '0;
			is_running   <= 1'b1;
			last         <= 1'b0;
		end else begin
			if (res_fire) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					res_cv_q    <= 1'b0;
					res_char_q  <= '0;
					res_instr_q <= '0;
					if (in_acc) begin
						if (!operation) begin
							res_status_q <= ST_OK;
							state_q      <= S_RES;
						end else if (!run_q) begin
							res_status_q <= ST_NOT_RUN;
							state_q      <= S_RES;
						end else if (pc_q >= ADDR_W'(MEM_WORDS)) begin
							run_q        <= 1'b0;
							res_status_q <= ST_PC_RANGE;
							state_q      <= S_RES;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					ir_q        <= rword;
					res_instr_q <= rword;
					pc_q        <= pc_q + 1'b1;
					state_q     <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (dec_q.op)
						OP_HALT: begin
							run_q        <= 1'b0;
							res_status_q <= ST_HALTED;
							state_q      <= S_RES;
						end
						OP_LOAD, OP_ADD: begin
							res_status_q <= ST_OK;
							state_q      <= S_MEM;
						end
						OP_STORE: begin
							res_status_q <= ST_OK;
							state_q      <= S_RES;
						end
						OP_NEG: begin
							regs_q[dec_q.r] <= -rval;
							res_status_q    <= ST_OK;
							state_q         <= S_RES;
						end
						OP_LDI: begin
							regs_q[dec_q.r] <= imm;
							res_status_q    <= ST_OK;
							state_q         <= S_RES;
						end
						OP_ADDI: begin
							regs_q[dec_q.r] <= sum_sat;
							res_status_q    <= sum_ovf ? ST_SATURATED : ST_OK;
							state_q         <= S_RES;
						end
						OP_JMP: begin
							pc_q         <= dec_q.mm;
							res_status_q <= ST_OK;
							state_q      <= S_RES;
						end
						OP_BSIGN: begin
							// Taken only when the register is nonzero and its sign
							// agrees with the sign of the instruction word.
							if ((rval > 0 && ir_q > 0) || (rval < 0 && ir_q < 0)) begin
								pc_q <= dec_q.mm;
							end
							res_status_q <= ST_OK;
							state_q      <= S_RES;
						end
						default: begin
							if (dec_q.r == IO_READ) begin
								regs_q[0]    <= $signed({7'd0, char_q});
								res_status_q <= ST_OK;
								state_q      <= S_RES;
							end else if (dec_q.r == IO_PRINT) begin
								res_cv_q     <= 1'b1;
								res_char_q   <= regs_q[0][7:0];
								res_status_q <= ST_OK;
								state_q      <= S_RES;
							end else if (dec_q.r == IO_STRING) begin
								addr_q       <= {1'b0, dec_q.mm};
								n_q          <= '0;
								str_st_q     <= ST_OK;
								res_status_q <= ST_OK;
								state_q      <= S_SCAN;
							end else begin
								res_status_q <= (dec_q.r >= IO_UNKNOWN_LO) ? ST_UNK_IO : ST_OK;
								state_q      <= S_RES;
							end
						end
					endcase
				end
				S_MEM: begin
					if (dec_q.op == OP_LOAD) begin
						regs_q[dec_q.r] <= rword;
					end else begin
						regs_q[dec_q.r] <= sum_sat;
						if (sum_ovf) begin
							res_status_q <= ST_SATURATED;
						end
					end
					state_q <= S_RES;
				end
				S_SCAN: begin
					// One word per cycle: the read of the next word is already issued.
					if (addr_q < 8'(MEM_WORDS) && n_q != NW'(MAX_STRING) && rword != 0) begin
						n_q    <= n_q + 1'b1;
						addr_q <= scan_next;
					end else begin
						if (addr_q < 8'(MEM_WORDS) && n_q == NW'(MAX_STRING) && rword != 0) begin
							str_st_q     <= ST_TRUNC;
							res_status_q <= ST_TRUNC;
						end else begin
							res_status_q <= ST_OK;
						end
						k_q <= '0;
						if (n_q == '0) begin
							state_q <= S_RES;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					state_q <= S_SOUT;
				end
				S_SOUT: begin
					if (slot_free) begin
						status          <= str_st_q;
						char_valid      <= 1'b1;
						char_out        <= rword[7:0];
						program_counter <= pc_q;
						instruction     <= ir_q;
						is_running      <= run_q;
						last            <= (k_q + 1'b1 == n_q);
						k_q             <= k_q + 1'b1;
						if (k_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_RES: begin
					if (slot_free) begin
						status          <= res_status_q;
						char_valid      <= res_cv_q;
						char_out        <= res_char_q;
						program_counter <= pc_q;
						instruction     <= res_instr_q;
						is_running      <= run_q;
						last            <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* hw/rtl/sdc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sdc_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/sdc_decode.sv */
// Splits an instruction word into sign, opcode, register and address digits.
module sdc_decode (
	input  logic signed [sdc_pkg::WORD_W-1:0] word,
	output sdc_pkg::dec_t                     dec
);
	import sdc_pkg::*;

	logic [13:0] mag;
	logic [13:0] rem1;
	logic [9:0]  rem2;
	logic [3:0]  op;
	logic [3:0]  rd;

	always_comb begin
		mag = word[WORD_W-1] ? 14'(-word) : word[13:0];
		op = '0;
		for (int k = 1; k <= 9; k++) begin
			if (mag >= 14'(k * 1000)) begin
				op = 4'(k);
			end
		end
		rem1 = mag - (14'(op) * 14'd1000);
		rd = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem1 >= 14'(k * 100)) begin
				rd = 4'(k);
			end
		end
		rem2 = rem1[9:0] - (10'(rd) * 10'd100);
		dec.op  = op;
		dec.r   = rd;
		dec.mm  = rem2[ADDR_W-1:0];
		dec.neg = word[WORD_W-1];
	end
endmodule
